// File: rtl/core/vm_byte_stack_unit_core_assert.svh
// ----------------------------------------------------------------------------
// vm_byte_stack_unit_core_assert.svh
// Assertion macros for the byte stack core; compiled out under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef VM_BYTE_STACK_UNIT_CORE_ASSERT_SVH
`define VM_BYTE_STACK_UNIT_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge out of reset.
`define VMBS_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define VMBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define VMBS_ASSERT_HOLD(label, cond, msg)
`define VMBS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/core/vmbs_pkg.sv
// ----------------------------------------------------------------------------
// vmbs_pkg
// Shared types, request codes and sizes for the byte stack core.
// ----------------------------------------------------------------------------
package vmbs_pkg;

    localparam int DEFAULT_STACK_BYTES = 4096;
    localparam int LANES               = 8;
    localparam int SP_W                = 13;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;
    localparam logic [1:0] REQ_STORE = 2'd3;

    localparam logic [1:0] SIZE_BYTE = 2'd0;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  size_code;
        logic [15:0] address;
        logic [63:0] write_data;
    } req_t;

    typedef struct packed {
        logic             ok;
        logic [63:0]      read_data;
        logic [SP_W-1:0]  stack_pointer;
    } rsp_t;

    // Per-lane enables between the lane mapper and the RAM bank
    typedef struct packed {
        logic [LANES-1:0] en;
        logic [LANES-1:0] we;
    } lane_ctl_t;

endpackage

// File: rtl/core/vmbs_ram.sv
// ----------------------------------------------------------------------------
// vmbs_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module vmbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         q
);

    logic [WIDTH-1:0] mem_q [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_q[addr] <= wdata;
            end
            q <= mem_q[addr];
        end
    end

endmodule

// File: rtl/core/vmbs_lane_map.sv
// ----------------------------------------------------------------------------
// vmbs_lane_map
// Map a byte address and size onto eight byte lanes: row, enables, data.
// ----------------------------------------------------------------------------
module vmbs_lane_map #(
    parameter int AW = 12,
    parameter int RW = 9
) (
    input  logic [AW-1:0]                         addr,
    input  logic [1:0]                            size_code,
    input  logic [63:0]                           wdata,
    input  logic                                  rd,
    input  logic                                  wr,
    output logic [vmbs_pkg::LANES-1:0][RW-1:0]    row,
    output vmbs_pkg::lane_ctl_t                   ctl,
    output logic [63:0]                           lane_wdata
);

    import vmbs_pkg::*;

    logic [2:0]            off;
    logic [RW-1:0]         base;
    logic [3:0]            nbytes;
    logic [LANES-1:0][2:0] idx;
    logic [LANES-1:0]      hit;

    always_comb
    begin
        off    = addr[2:0];
        base   = RW'(addr >> 3);
        nbytes = 4'd1 << size_code;
        for (int l = 0; l < LANES; l++)
        begin
            // byte of the value that falls in this lane
            idx[l] = 3'(l) - off;
            hit[l] = {1'b0, idx[l]} < nbytes;
            // lanes below the offset wrap into the next row
            row[l] = (3'(l) < off) ? base + RW'(1) : base;
            ctl.en[l] = hit[l] & (rd | wr);
            ctl.we[l] = hit[l] & wr;
            lane_wdata[8*l +: 8] = wdata[8*idx[l] +: 8];
        end
    end

endmodule

// File: rtl/core/vmbs_rd_align.sv
// ----------------------------------------------------------------------------
// vmbs_rd_align
// Rotate lane read data back into value order and zero unused bytes.
// ----------------------------------------------------------------------------
module vmbs_rd_align (
    input  logic [63:0] lane_q,
    input  logic [2:0]  off,
    input  logic [1:0]  size_code,
    input  logic        valid,
    output logic [63:0] data
);

    import vmbs_pkg::*;

    logic [3:0]            nbytes;
    logic [LANES-1:0][2:0] src;

    always_comb
    begin
        nbytes = 4'd1 << size_code;
        for (int i = 0; i < LANES; i++)
        begin
            src[i] = 3'(i) + off;
            data[8*i +: 8] = (valid && (4'(i) < nbytes)) ? lane_q[8*src[i] +: 8] : 8'h00;
        end
    end

endmodule

// File: rtl/core/vm_byte_stack_unit_core.sv
// ----------------------------------------------------------------------------
// vm_byte_stack_unit_core
// Byte-addressed VM stack: push/pop at the top, load/store at any offset.
//
//   channel   handshake         payload             direction
//   request   start / busy      req  (req_t)        in
//   result    done (strobe)     rsp  (rsp_t)        out
//
// For a request beat, the accept cycle resolves the bounds check, moves
// the top and drives the byte-lane RAMs that the access covers at once
// (write or read); the next cycle aligns the registered lane data and pulses
// done. Busy stays high meanwhile, so no new beat is taken until the result is out.
// After reset a clearing pass zeroes the store, one row of eight bytes per
// cycle, with busy held high throughout.
// The result strobe cannot be stalled; each result shows for one cycle only.
// ----------------------------------------------------------------------------
`include "vm_byte_stack_unit_core_assert.svh"

module vm_byte_stack_unit_core #(
    parameter int STACK_BYTES = vmbs_pkg::DEFAULT_STACK_BYTES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  vmbs_pkg::req_t req,
    output logic           done,
    output vmbs_pkg::rsp_t rsp
);

    import vmbs_pkg::*;

    localparam int AW    = $clog2(STACK_BYTES);
    localparam int CW    = AW + 1;
    localparam int DEPTH = (STACK_BYTES + LANES - 1) / LANES;
    localparam int RW    = $clog2(DEPTH);

    localparam logic [CW-1:0] CAP      = CW'(STACK_BYTES);
    localparam logic [16:0]   CAP_EXT  = 17'(STACK_BYTES);
    localparam logic [RW-1:0] LAST_ROW = RW'(DEPTH - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RESP  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] top_reg, top_next;
    logic [RW-1:0] clr_row_reg, clr_row_next;
    logic          ok_reg, rd_reg;
    logic [2:0]    off_reg;
    logic [1:0]    size_reg;

    logic          accept;
    logic [3:0]    nbytes;
    logic          push_fit, pop_fit, ls_fit;
    logic          ok_now, rd_now, wr_now;
    logic [AW-1:0] acc_addr;

    logic [LANES-1:0][RW-1:0] map_row, ram_row;
    lane_ctl_t                map_ctl, ram_ctl;
    logic [63:0]              map_wdata, ram_wdata;
    logic [LANES-1:0][7:0]    lane_q;
    logic [63:0]              rd_data;
    logic [AW+SP_W-1:0]       sp_wide;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Bounds checks and access address, all from the request and the live top
    always_comb
    begin
        nbytes   = 4'd1 << req.size_code;
        push_fit = ({1'b0, top_reg} + CW'(nbytes)) < CAP;
        pop_fit  = top_reg >= AW'(nbytes);
        ls_fit   = (req.size_code != SIZE_BYTE)
                   && ((17'(req.address) + 17'(nbytes)) <= CAP_EXT);
        case (req.req_type)
            REQ_PUSH:
            begin
                ok_now   = push_fit;
                acc_addr = top_reg;
            end
            REQ_POP:
            begin
                ok_now   = pop_fit;
                acc_addr = top_reg - AW'(nbytes);
            end
            default:
            begin
                ok_now   = ls_fit;
                acc_addr = AW'(req.address);
            end
        endcase
        rd_now = accept && ok_now && (req.req_type inside {REQ_POP, REQ_LOAD});
        wr_now = accept && ok_now && (req.req_type inside {REQ_PUSH, REQ_STORE});
    end

    vmbs_lane_map #(
        .AW (AW),
        .RW (RW)
    ) u_lane_map (
        .addr       (acc_addr),
        .size_code  (req.size_code),
        .wdata      (req.write_data),
        .rd         (rd_now),
        .wr         (wr_now),
        .row        (map_row),
        .ctl        (map_ctl),
        .lane_wdata (map_wdata)
    );

    // Clearing pass owns every lane until the store is zeroed
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                ram_row[l] = clr_row_reg;
            end
            ram_ctl.en = '1;
            ram_ctl.we = '1;
            ram_wdata  = '0;
        end
        else
        begin
            ram_row   = map_row;
            ram_ctl   = map_ctl;
            ram_wdata = map_wdata;
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        vmbs_ram #(
            .WIDTH (8),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .en    (ram_ctl.en[l]),
            .we    (ram_ctl.we[l]),
            .addr  (ram_row[l]),
            .wdata (ram_wdata[8*l +: 8]),
            .q     (lane_q[l])
        );
    end

    // Sequencer: clear after reset, then accept / respond
    always_comb
    begin
        state_next   = state_reg;
        top_next     = top_reg;
        clr_row_next = clr_row_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_row_next = clr_row_reg + RW'(1);
                if (clr_row_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RESP;
                    // advance on push, retreat on pop; load/store hold the top
                    if (ok_now && (req.req_type == REQ_PUSH))
                    begin
                        top_next = top_reg + AW'(nbytes);
                    end
                    else if (ok_now && (req.req_type == REQ_POP))
                    begin
                        top_next = acc_addr;
                    end
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            top_reg     <= '0;
            clr_row_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            clr_row_reg <= clr_row_next;
        end
    end

    // Hold what the response cycle needs to shape the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg   <= ok_now;
            rd_reg   <= rd_now;
            off_reg  <= acc_addr[2:0];
            size_reg <= req.size_code;
        end
    end

    vmbs_rd_align u_rd_align (
        .lane_q    (lane_q),
        .off       (off_reg),
        .size_code (size_reg),
        .valid     (rd_reg),
        .data      (rd_data)
    );

    assign sp_wide           = {{SP_W{1'b0}}, top_reg};
    assign done              = (state_reg == ST_RESP);
    assign rsp.ok            = ok_reg;
    assign rsp.read_data     = rd_data;
    assign rsp.stack_pointer = sp_wide[SP_W-1:0];

    // Every accepted beat yields its result strobe in the very next cycle
    `VMBS_ASSERT_NEXT(a_accept_gives_done, start && !busy, done, "accepted beat gave no result")
    // A result strobe lasts one cycle
    `VMBS_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")
    // The top never reaches the capacity
    `VMBS_ASSERT_HOLD(a_top_in_range, ({1'b0, top_reg} < CAP), "stack top at or past capacity")
    // A failed request returns no data
    `VMBS_ASSERT_HOLD(a_fail_zero, !done || rsp.ok || (rsp.read_data == '0), "data on failed beat")

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vm_byte_stack_unit_core. Request beats are driven
// on the falling edge; an in-bench model of the stack pointer and the byte
// store predicts each result, which is checked field by field on the rising
// edge at which done is seen. Directed beats cover the bounds and the
// rejected one-byte accesses. Random phases then fill the stack until it
// overflows, mix all requests, drain it until it underflows, and churn near
// the bottom with no idling.
// ----------------------------------------------------------------------------
module testbench;

    import vmbs_pkg::*;

    localparam int STACK       = DEFAULT_STACK_BYTES;
    // Longest quiet stretch: clearing pass after reset plus the longest idle
    // burst and a request beat, taken several times over.
    localparam int STALL_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    vm_byte_stack_unit_core #(
        .STACK_BYTES(STACK)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model of the stack: its own top pointer and byte image, both cleared as
    // the core clears its store after reset.
    // ------------------------------------------------------------------------
    logic [7:0]  stack_image [0:STACK-1];
    int unsigned model_top;
    rsp_t        pending_rsp [$];

    int unsigned push_overflows;
    int unsigned pop_underflows;
    int unsigned access_rejects;
    int unsigned beats_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned idle_cycles;
    bit          idle_on;

    initial
    begin
        for (int i = 0; i < STACK; i++)
            stack_image[i] = 8'h00;
        model_top      = 0;
        push_overflows = 0;
        pop_underflows = 0;
        access_rejects = 0;
        beats_sent     = 0;
        results_seen   = 0;
        mismatches     = 0;
        idle_cycles    = 0;
        idle_on        = 1'b1;
    end

    // Work out the result of one request beat and advance the model state.
    function automatic rsp_t predict_stack_op(input req_t r);
        rsp_t        res;
        int unsigned n;
        int unsigned a;
        n             = 1 << r.size_code;
        a             = 32'(r.address);
        res.ok        = 1'b0;
        res.read_data = '0;
        case (r.req_type)
            REQ_PUSH:
            begin
                // The last byte of the store can never be pushed.
                if (model_top + n < STACK)
                begin
                    for (int i = 0; i < n; i++)
                        stack_image[model_top + i] = r.write_data[8*i +: 8];
                    model_top = model_top + n;
                    res.ok    = 1'b1;
                end
                else
                    push_overflows++;
            end
            REQ_POP:
            begin
                if (model_top >= n)
                begin
                    model_top = model_top - n;
                    for (int i = 0; i < n; i++)
                        res.read_data[8*i +: 8] = stack_image[model_top + i];
                    res.ok = 1'b1;
                end
                else
                    pop_underflows++;
            end
            default:
            begin
                // Load and store: no one-byte access, no access past the end.
                if (r.size_code != SIZE_BYTE && a + n <= STACK)
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        if (r.req_type == REQ_LOAD)
                            res.read_data[8*i +: 8] = stack_image[a + i];
                        else
                            stack_image[a + i] = r.write_data[8*i +: 8];
                    end
                    res.ok = 1'b1;
                end
                else
                    access_rejects++;
            end
        endcase
        res.stack_pointer = model_top[SP_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at result %0d: %0s got %0h want %0h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: check the result seen on this edge against the oldest
    // expectation first, then queue the prediction for a beat accepted here.
    // ------------------------------------------------------------------------
    rsp_t want_rsp;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_rsp.size() == 0)
                    report_mismatch("unexpected result", rsp.read_data, '0);
                else
                begin
                    want_rsp = pending_rsp.pop_front();
                    if (rsp.ok !== want_rsp.ok)
                        report_mismatch("ok", 64'(rsp.ok), 64'(want_rsp.ok));
                    if (rsp.read_data !== want_rsp.read_data)
                        report_mismatch("read_data", rsp.read_data, want_rsp.read_data);
                    if (rsp.stack_pointer !== want_rsp.stack_pointer)
                        report_mismatch("stack_pointer", 64'(rsp.stack_pointer),
                                        64'(want_rsp.stack_pointer));
                end
                results_seen++;
            end
            if (start && !busy)
                pending_rsp.push_back(predict_stack_op(req));
        end
    end

    // Watchdog: count edges at which no beat moves either way.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
            $display("FAIL vm_byte_stack_unit_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic req_t make_req(input logic [1:0] kind, input logic [1:0] sc,
                                      input logic [15:0] addr, input logic [63:0] data);
        req_t r;
        r.req_type   = kind;
        r.size_code  = sc;
        r.address    = addr;
        r.write_data = data;
        return r;
    endfunction

    function automatic logic [63:0] rand_data();
        return {$urandom, $urandom};
    endfunction

    // Mostly in range, some right at the end of the store, some anywhere in
    // the 16-bit space so that every address bit toggles.
    function automatic logic [15:0] rand_address(input logic [1:0] sc);
        int unsigned n;
        int unsigned pick;
        n    = 1 << sc;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 16'($urandom_range(0, STACK - n));
        else if (pick < 8)
            return 16'($urandom_range(STACK - 12, STACK - 1));
        else
            return 16'($urandom);
    endfunction

    // push_w and pop_w are percentages; big_w biases push and pop to eight bytes.
    function automatic req_t rand_req(input int unsigned push_w, input int unsigned pop_w,
                                      input int unsigned big_w);
        int unsigned pick;
        logic [1:0]  kind;
        logic [1:0]  sc;
        pick = $urandom_range(0, 99);
        if (pick < push_w)
            kind = REQ_PUSH;
        else if (pick < push_w + pop_w)
            kind = REQ_POP;
        else
            kind = ($urandom_range(0, 1) == 0) ? REQ_LOAD : REQ_STORE;
        if ((kind == REQ_PUSH || kind == REQ_POP) && $urandom_range(0, 99) < big_w)
            sc = 2'd3;
        else
            sc = 2'($urandom_range(0, 3));
        return make_req(kind, sc, rand_address(sc), rand_data());
    endfunction

    // Hold one beat on the request port until it is taken, then maybe idle.
    // Called at a falling edge; returns at a falling edge.
    task automatic send_beat(input req_t item);
        start = 1'b1;
        req   = item;
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 18))
            begin
                // Drive noise while idle; the core must ignore it.
                req = {$urandom, $urandom, 20'($urandom)};
                @(negedge clk);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Store is cleared and the stack empty straight after reset.
    task automatic test_reset_state();
        send_beat(make_req(REQ_LOAD, 2'd3, 16'd0, rand_data()));
        send_beat(make_req(REQ_LOAD, 2'd1, 16'(STACK - 2), rand_data()));
        send_beat(make_req(REQ_POP, 2'd0, 16'd0, rand_data()));
    endtask

    // Every push and pop size, with junk above the used bytes; then underflow.
    task automatic test_push_pop();
        send_beat(make_req(REQ_PUSH, 2'd0, 16'hFFFF, 64'hFEDC_BA98_7654_3210));
        send_beat(make_req(REQ_PUSH, 2'd1, 16'h0000, 64'h1234_5678_9ABC_A55A));
        send_beat(make_req(REQ_PUSH, 2'd2, 16'h8000, 64'hFFFF_FFFF_8000_0001));
        send_beat(make_req(REQ_PUSH, 2'd3, 16'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_beat(make_req(REQ_POP, 2'd3, 16'h0000, 64'h0));
        send_beat(make_req(REQ_POP, 2'd2, 16'h0000, 64'h0));
        send_beat(make_req(REQ_POP, 2'd1, 16'h0000, 64'h0));
        send_beat(make_req(REQ_POP, 2'd0, 16'h0000, 64'h0));
        send_beat(make_req(REQ_POP, 2'd1, 16'h0000, 64'h0));
        send_beat(make_req(REQ_PUSH, 2'd0, 16'h0000, 64'h0000_0000_0000_00C3));
    endtask

    // One-byte rejects and the edges of the addressable range.
    task automatic test_load_store();
        send_beat(make_req(REQ_STORE, SIZE_BYTE, 16'd0, 64'hFF));
        send_beat(make_req(REQ_LOAD, SIZE_BYTE, 16'd0, 64'h0));
        send_beat(make_req(REQ_STORE, 2'd3, 16'(STACK - 8), 64'h0123_4567_89AB_CDEF));
        send_beat(make_req(REQ_LOAD, 2'd3, 16'(STACK - 8), 64'h0));
        send_beat(make_req(REQ_STORE, 2'd3, 16'(STACK - 7), 64'hFFFF_FFFF_FFFF_FFFF));
        send_beat(make_req(REQ_LOAD, 2'd1, 16'(STACK - 2), 64'h0));
        send_beat(make_req(REQ_LOAD, 2'd1, 16'(STACK - 1), 64'h0));
        send_beat(make_req(REQ_LOAD, 2'd2, 16'hFFFF, 64'h0));
        send_beat(make_req(REQ_STORE, 2'd2, 16'h8000, 64'hFFFF_FFFF));
        send_beat(make_req(REQ_STORE, 2'd1, 16'd0, 64'h5555_5555_5555_AAAA));
        send_beat(make_req(REQ_LOAD, 2'd2, 16'd0, 64'h0));
    endtask

    // Push mostly eight-byte values until the stack has overflowed several times.
    task automatic test_fill_overflow();
        int unsigned guard;
        int unsigned base;
        guard = 0;
        base  = push_overflows;
        while (push_overflows < base + 8 && guard < 1500)
        begin
            send_beat(rand_req(92, 2, 95));
            guard++;
        end
    endtask

    // All requests at random around wherever the top now stands.
    task automatic test_random_mix();
        repeat (60)
            send_beat(rand_req(35, 35, 0));
    endtask

    // Pop mostly eight bytes at a time until the stack has underflowed repeatedly.
    task automatic test_drain_underflow();
        int unsigned guard;
        int unsigned base;
        guard = 0;
        base  = pop_underflows;
        while (pop_underflows < base + 8 && guard < 1500)
        begin
            send_beat(rand_req(2, 92, 95));
            guard++;
        end
    endtask

    // Back-to-back beats near the bottom of the stack, no idling at all.
    task automatic test_bottom_churn();
        idle_on = 1'b0;
        repeat (80)
            send_beat(rand_req(40, 40, 0));
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned guard;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_push_pop();
        test_load_store();
        test_fill_overflow();
        test_random_mix();
        test_drain_underflow();
        test_bottom_churn();

        start = 1'b0;
        guard = 0;
        while (pending_rsp.size() != 0 && guard < 200)
        begin
            @(posedge clk);
            guard++;
        end
        // Allow for a stray result after the last expected one.
        repeat (8) @(posedge clk);
        if (pending_rsp.size() != 0)
            report_mismatch("expectations left over", 64'(pending_rsp.size()), '0);

        $display("covered %0d request beats, %0d results, %0d mismatches",
                 beats_sent, results_seen, mismatches);
        $display("push overflows %0d, pop underflows %0d, load/store rejects %0d",
                 push_overflows, pop_underflows, access_rejects);
        if (mismatches == 0)
            $display("PASS vm_byte_stack_unit_core");
        else
            $display("FAIL vm_byte_stack_unit_core");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/vmbs_pkg.sv
rtl/core/vmbs_ram.sv
rtl/core/vmbs_lane_map.sv
rtl/core/vmbs_rd_align.sv
rtl/core/vm_byte_stack_unit_core.sv
tb/sv/testbench.sv
